@@ hdl/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH = 8;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OCC_W = 4;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] key;
   } entry_type;

   // Command broadcast to every cell in the chain
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type entry;
   } cell_cmd_type;

endpackage

@@ hdl/spq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares its key with the
// incoming one and takes its own, the new, or a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_cmd_type cmd,
   input  logic                 occ_here,
   input  logic                 left_occ,
   input  logic                 left_greater,
   input  spq_pkg::entry_type   left_entry,
   input  spq_pkg::entry_type   right_entry,
   output spq_pkg::entry_type   entry_out,
   output logic                 greater
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      open_slot;

   // Key strictly greater than the new key: this entry moves back one slot
   assign greater   = occ_here && (entry_ff.key > cmd.entry.key);
   assign open_slot = !occ_here || greater;
   assign entry_out = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.remove) begin
         entry_in = right_entry;
      end else if (cmd.insert && open_slot) begin
         if (left_greater) begin
            entry_in = left_entry;
         end else if (left_occ) begin
            entry_in = cmd.entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ hdl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted-array priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// A command (insert or remove) is taken on any cycle with start high; busy
// never rises, so one command per cycle is sustained. Every slot compares its
// key with the new one in the same cycle and shifts in parallel. The response
// follows in the cycle after the transfer and is shown for that single cycle
// with rsp_strobe; the receiver cannot stall it. Equal keys leave in arrival
// order; an insert into a full queue and a remove from an empty one leave the
// contents unchanged.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_mode,
   input  logic signed [31:0]         req_entry_value,
   input  logic signed [31:0]         req_entry_priority,
   output logic                       rsp_strobe,
   output logic signed [31:0]         rsp_taken_value,
   output logic signed [31:0]         rsp_taken_priority,
   output logic [1:0]                 rsp_status,
   output logic signed [31:0]         rsp_head_value,
   output logic signed [31:0]         rsp_head_priority,
   output logic [3:0]                 rsp_occupancy
);
   import spq_pkg::*;

   logic              accept;
   logic              is_remove;
   logic              full;
   logic              empty;
   cell_cmd_type      cmd;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [DEPTH-1:0]  occ;
   logic [DEPTH-1:0]  greater;
   entry_type         slot [DEPTH];
   entry_type         head_in;
   status_type        status_in;
   entry_type         taken_in;

   logic              strobe_ff;
   entry_type         taken_ff;
   entry_type         head_ff;
   status_type        status_ff;
   logic [OCC_W-1:0]  occ_ff;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign is_remove = (mode_type'(req_mode) == MODE_REMOVE);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   assign cmd.insert      = accept && !is_remove && !full;
   assign cmd.remove      = accept && is_remove && !empty;
   assign cmd.entry.value = req_entry_value;
   assign cmd.entry.key   = req_entry_priority;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         assign occ[i] = (count_ff > CNT_W'(i));
         if (i == 0) begin : g_head
            spq_cell u_cell (
               .clock        (clock),
               .cmd          (cmd),
               .occ_here     (occ[i]),
               .left_occ     (1'b1),
               .left_greater (1'b0),
               .left_entry   ('0),
               .right_entry  (slot[i+1]),
               .entry_out    (slot[i]),
               .greater      (greater[i])
            );
         end else if (i == DEPTH - 1) begin : g_tail
            spq_cell u_cell (
               .clock        (clock),
               .cmd          (cmd),
               .occ_here     (occ[i]),
               .left_occ     (occ[i-1]),
               .left_greater (greater[i-1]),
               .left_entry   (slot[i-1]),
               .right_entry  ('0),
               .entry_out    (slot[i]),
               .greater      (greater[i])
            );
         end else begin : g_mid
            spq_cell u_cell (
               .clock        (clock),
               .cmd          (cmd),
               .occ_here     (occ[i]),
               .left_occ     (occ[i-1]),
               .left_greater (greater[i-1]),
               .left_entry   (slot[i-1]),
               .right_entry  (slot[i+1]),
               .entry_out    (slot[i]),
               .greater      (greater[i])
            );
         end
      end
   endgenerate

   // Count, status, taken entry and the head as it will stand after this command
   always_comb begin
      count_in  = count_ff;
      status_in = ST_DONE;
      taken_in  = '0;
      head_in   = slot[0];
      priority if (accept && !is_remove) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
            // new entry lands at the head if the head moves back or is empty
            if (!occ[0] || greater[0]) begin
               head_in = cmd.entry;
            end
         end
      end else if (accept) begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            count_in = count_ff - CNT_W'(1);
            taken_in = slot[0];
            head_in  = slot[1];
         end
      end
      if (count_in == '0) begin
         head_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         taken_ff  <= taken_in;
         head_ff   <= head_in;
         status_ff <= status_in;
         occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_taken_value    = taken_ff.value;
   assign rsp_taken_priority = taken_ff.key;
   assign rsp_status         = status_ff;
   assign rsp_head_value     = head_ff.value;
   assign rsp_head_priority  = head_ff.key;
   assign rsp_occupancy      = occ_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not raise the count");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("remove did not lower the count");

   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && status_ff == ST_EMPTY) |-> (count_ff == '0 && head_ff == '0))
      else $error("empty refusal with entries held");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted priority queue. A shadow copy of the
// queue predicts one reply per accepted command. A monitor checks each
// strobed reply field by field against the oldest prediction. The bench runs
// a directed pass over full, empty, equal-key and extreme-key cases, then
// random traffic with several sender idle rates and fill-level biases.
// ----------------------------------------------------------------------------
module tb;
   import spq_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] taken_value;
      logic signed [DATA_W-1:0] taken_priority;
      status_type               status;
      logic signed [DATA_W-1:0] head_value;
      logic signed [DATA_W-1:0] head_priority;
      logic [OCC_W-1:0]         occupancy;
   } queue_reply_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_mode;
   logic signed [DATA_W-1:0] req_entry_value;
   logic signed [DATA_W-1:0] req_entry_priority;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_taken_value;
   logic signed [DATA_W-1:0] rsp_taken_priority;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_head_value;
   logic signed [DATA_W-1:0] rsp_head_priority;
   logic [3:0]               rsp_occupancy;

   entry_type       shadow_slots [DEPTH];
   int              shadow_fill;
   queue_reply_type owed_replies [$];
   queue_reply_type due_reply;
   int              mismatches;
   int              sender_idle_pct;

   sorted_priority_queue i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_entry_value    (req_entry_value),
      .req_entry_priority (req_entry_priority),
      .rsp_strobe         (rsp_strobe),
      .rsp_taken_value    (rsp_taken_value),
      .rsp_taken_priority (rsp_taken_priority),
      .rsp_status         (rsp_status),
      .rsp_head_value     (rsp_head_value),
      .rsp_head_priority  (rsp_head_priority),
      .rsp_occupancy      (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one command to the shadow queue and returns the reply it owes.
   function automatic queue_reply_type apply_queue_op(mode_type op,
                                                      logic signed [DATA_W-1:0] val,
                                                      logic signed [DATA_W-1:0] key);
      queue_reply_type r;
      int              pos;
      int              i;
      r = '0;
      r.status = ST_DONE;
      if (op == MODE_INSERT) begin
         if (shadow_fill >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            // new entry lands behind every key that is not greater
            pos = shadow_fill;
            while (pos > 0 && shadow_slots[pos-1].key > key) begin
               shadow_slots[pos] = shadow_slots[pos-1];
               pos--;
            end
            shadow_slots[pos].value = val;
            shadow_slots[pos].key = key;
            shadow_fill++;
         end
      end else if (shadow_fill == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.taken_value = shadow_slots[0].value;
         r.taken_priority = shadow_slots[0].key;
         for (i = 0; i + 1 < shadow_fill; i++) begin
            shadow_slots[i] = shadow_slots[i+1];
         end
         shadow_fill--;
      end
      if (shadow_fill != 0) begin
         r.head_value = shadow_slots[0].value;
         r.head_priority = shadow_slots[0].key;
      end
      r.occupancy = OCC_W'(shadow_fill);
      return r;
   endfunction

   task automatic check_field(string name, logic [DATA_W-1:0] exp_val,
                              logic [DATA_W-1:0] got_val);
      if (got_val !== exp_val) begin
         if (mismatches < 40) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, got_val);
         end
         mismatches++;
      end
   endtask

   // Prediction happens before the check so the oldest entry is always the
   // one owed by the strobed reply.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            owed_replies.push_back(apply_queue_op(mode_type'(req_mode),
                                                  req_entry_value, req_entry_priority));
         end
         if (rsp_strobe === 1'b1) begin
            if (owed_replies.size() == 0) begin
               $display("%0t: reply strobe expected none actual status %0d", $time,
                        rsp_status);
               mismatches++;
            end else begin
               due_reply = owed_replies.pop_front();
               check_field("taken_value", due_reply.taken_value, rsp_taken_value);
               check_field("taken_priority", due_reply.taken_priority,
                           rsp_taken_priority);
               check_field("status", DATA_W'(due_reply.status), DATA_W'(rsp_status));
               check_field("head_value", due_reply.head_value, rsp_head_value);
               check_field("head_priority", due_reply.head_priority, rsp_head_priority);
               check_field("occupancy", DATA_W'(due_reply.occupancy),
                           DATA_W'(rsp_occupancy));
            end
         end
      end
   end

   // One command transfer, with a random idle gap ahead of it.
   task automatic send_op(mode_type op, logic signed [DATA_W-1:0] val,
                          logic signed [DATA_W-1:0] key);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_mode = op;
      req_entry_value = val;
      req_entry_priority = key;
      do @(posedge clock); while (busy);
   endtask

   // Sender holds off until every reply is back.
   task automatic wait_queue_quiet();
      @(negedge clock);
      start = 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic test_directed_edges();
      sender_idle_pct = 0;
      // remove from empty, unused fields nonzero
      send_op(MODE_REMOVE, 32'sh7FFFFFFF, 32'sh80000000);
      send_op(MODE_INSERT, 32'sh7FFFFFFF, 32'sh80000000);
      send_op(MODE_INSERT, 32'sh80000000, 32'sh7FFFFFFF);
      send_op(MODE_INSERT, 32'sh00000000, 32'sh00000000);
      send_op(MODE_INSERT, 32'shFFFFFFFF, 32'shFFFFFFFF);
      // equal keys must leave in arrival order
      send_op(MODE_INSERT, 32'sh00000001, 32'sh00000005);
      send_op(MODE_INSERT, 32'sh00000002, 32'sh00000005);
      send_op(MODE_INSERT, 32'sh00000003, 32'sh00000005);
      send_op(MODE_INSERT, 32'sh55555555, 32'sh80000000);
      // full: would have landed behind the equal head keys
      send_op(MODE_INSERT, 32'shAAAAAAAA, 32'sh80000000);
      repeat (DEPTH + 1) send_op(MODE_REMOVE, 32'shFFFFFFFF, 32'shFFFFFFFF);
      wait_queue_quiet();
   endtask

   task automatic test_random_traffic(int idle_pct, int n_ops);
      int                       k;
      int                       ins_pct;
      mode_type                 op;
      logic signed [DATA_W-1:0] key;
      sender_idle_pct = idle_pct;
      ins_pct = 50;
      for (k = 0; k < n_ops; k++) begin
         // fill-level bias changes every few dozen commands so full and
         // empty both get hit
         if (k % 40 == 0) begin
            case ($urandom_range(2))
               0: ins_pct = 25;
               1: ins_pct = 50;
               default: ins_pct = 75;
            endcase
         end
         op = ($urandom_range(99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
         case ($urandom_range(9))
            0, 1, 2, 3: key = $signed($urandom_range(6)) - 3;
            4: key = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: key = $urandom;
         endcase
         send_op(op, $urandom, key);
      end
      wait_queue_quiet();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_mode = MODE_INSERT;
      req_entry_value = '0;
      req_entry_priority = '0;
      shadow_fill = 0;
      mismatches = 0;
      sender_idle_pct = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_random_traffic(0, 300);
      test_random_traffic(82, 300);
      test_random_traffic(18, 300);
      test_random_traffic(0, 290);

      if (mismatches == 0 && owed_replies.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
